FILE: sv/lfe_pkg.sv
// ----------------------------------------------------------------------------
// lfe_pkg
// Shared constants, types and the brightness gain table of the LED frame
// encoder.
// ----------------------------------------------------------------------------
package lfe_pkg;

  localparam int NUM_LEDS     = 24;
  localparam int RESET_SLOTS  = 50;
  localparam int BITS_PER_LED = 24;
  localparam int MAX_ANGLE    = 45;

  localparam int ADDR_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int LED_W   = $clog2(NUM_LEDS + 1);
  localparam int RST_W   = (RESET_SLOTS > 1) ? $clog2(RESET_SLOTS) : 1;
  localparam int BIT_W   = 5;
  localparam int WORD_W  = 24;
  localparam int GAIN_W  = 17;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_DUTY_ONE   = 2'd1;
  localparam logic [1:0] REG_DUTY_ZERO  = 2'd2;

  localparam logic [5:0] BRIGHTNESS_RESET = 6'd45;
  localparam logic [7:0] DUTY_ONE_RESET   = 8'd60;
  localparam logic [7:0] DUTY_ZERO_RESET  = 8'd30;

  // Per-slot control handed from the slot sequencer to the encoder stage.
  typedef struct packed {
    logic             active;
    logic             load;
    logic             in_data;
    logic [BIT_W-1:0] bit_idx;
    logic             frame_end;
  } slot_info_t;

  typedef struct packed {
    logic sending;
    logic in_data;
  } ctrl_status_t;

  // round(tan(angle degrees) * 65536)
  function automatic logic [GAIN_W-1:0] tan_q16(input logic [5:0] angle);
    logic [GAIN_W-1:0] g;
    case (angle)
      6'd0:  g = 17'd0;      6'd1:  g = 17'd1144;   6'd2:  g = 17'd2289;
      6'd3:  g = 17'd3435;   6'd4:  g = 17'd4583;   6'd5:  g = 17'd5734;
      6'd6:  g = 17'd6888;   6'd7:  g = 17'd8047;   6'd8:  g = 17'd9210;
      6'd9:  g = 17'd10380;  6'd10: g = 17'd11556;  6'd11: g = 17'd12739;
      6'd12: g = 17'd13930;  6'd13: g = 17'd15130;  6'd14: g = 17'd16340;
      6'd15: g = 17'd17560;  6'd16: g = 17'd18792;  6'd17: g = 17'd20036;
      6'd18: g = 17'd21294;  6'd19: g = 17'd22566;  6'd20: g = 17'd23853;
      6'd21: g = 17'd25157;  6'd22: g = 17'd26478;  6'd23: g = 17'd27818;
      6'd24: g = 17'd29179;  6'd25: g = 17'd30560;  6'd26: g = 17'd31964;
      6'd27: g = 17'd33392;  6'd28: g = 17'd34846;  6'd29: g = 17'd36327;
      6'd30: g = 17'd37837;  6'd31: g = 17'd39378;  6'd32: g = 17'd40951;
      6'd33: g = 17'd42560;  6'd34: g = 17'd44205;  6'd35: g = 17'd45889;
      6'd36: g = 17'd47615;  6'd37: g = 17'd49385;  6'd38: g = 17'd51202;
      6'd39: g = 17'd53070;  6'd40: g = 17'd54991;  6'd41: g = 17'd56970;
      6'd42: g = 17'd59009;  6'd43: g = 17'd61113;  6'd44: g = 17'd63287;
      default: g = 17'd65536;
    endcase
    return g;
  endfunction

endpackage

FILE: sv/addressable_led_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// addressable_led_frame_encoder_top
// Pixel store and PWM bit encoder for a chain of addressable LEDs.
// ----------------------------------------------------------------------------
// The block takes one input transfer per clock cycle while the output side
// keeps up. Pixel writes and frame starts produce nothing; each slot tick
// produces exactly one output transfer: the stage register captures the slot
// and reads the pixel store, then the output register takes the scaled pixel
// and the picked duty value. The pixel store comes out of reset reading zero in
// every entry, with no clearing pass. If the output side stalls, two ticks are
// held inside before the input side is held off.
module addressable_led_frame_encoder_top
  import lfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // led_index[9:0], red[17:10], green[25:18], blue[33:26]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // duty[7:0]
  output logic [0:0]  m_tuser,   // frame_active[0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic              accept;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic              tick;
  slot_info_t        info;
  ctrl_status_t      status;
  logic [5:0]        brightness;
  logic [7:0]        duty_one;
  logic [7:0]        duty_zero;
  logic              active_bit;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHTNESS_RESET;
      duty_one   <= DUTY_ONE_RESET;
      duty_zero  <= DUTY_ZERO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRIGHTNESS: begin
          brightness <= (cfg_data[5:0] > 6'(MAX_ANGLE)) ? 6'(MAX_ANGLE) : cfg_data[5:0];
        end
        REG_DUTY_ONE:  duty_one  <= cfg_data;
        REG_DUTY_ZERO: duty_zero <= cfg_data;
        default: ;
      endcase
    end
  end

  lfe_slot_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (s_tuser),
    .led_index (s_tdata[9:0]),
    .red       (s_tdata[17:10]),
    .green     (s_tdata[25:18]),
    .blue      (s_tdata[33:26]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .tick      (tick),
    .info      (info),
    .status    (status)
  );

  lfe_pixel_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lfe_encode u_enc (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .info       (info),
    .pixel      (mem_rdata),
    .brightness (brightness),
    .duty_one   (duty_one),
    .duty_zero  (duty_zero),
    .ready      (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_duty   (m_tdata),
    .out_active (active_bit),
    .out_end    (m_tlast)
  );

  assign m_tuser[0] = active_bit;

  a_end_stops_frame: assert property (@(posedge clk) disable iff (rst)
    tick && info.frame_end |=> !status.sending)
    else $error("frame still running after its last reset slot");

  a_start_begins_frame: assert property (@(posedge clk) disable iff (rst)
    accept && (s_tuser == ACT_START) |=> status.sending)
    else $error("frame start did not take effect");

  a_idle_duty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata == 8'd0) && !m_tlast)
    else $error("idle slot carries a nonzero duty or a frame end");

  a_end_in_reset_slots: assert property (@(posedge clk) disable iff (rst)
    tick && info.frame_end |-> !status.in_data && !info.load)
    else $error("frame end raised inside the pixel data");

endmodule

FILE: sv/lfe_pixel_mem.sv
// ----------------------------------------------------------------------------
// lfe_pixel_mem
// Pixel store: one green-red-blue word per LED, registered read, with a
// valid bit per entry so that entries never written read as zero.
// ----------------------------------------------------------------------------
module lfe_pixel_mem
  import lfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0]   mem [NUM_LEDS];
  logic [NUM_LEDS-1:0] valid;
  logic [WORD_W-1:0]   rd_word;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_word <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_valid <= valid[raddr];
      end
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

FILE: sv/lfe_slot_ctrl.sv
// ----------------------------------------------------------------------------
// lfe_slot_ctrl
// Slot sequencer: decodes accepted items, writes pixels, tracks the LED, bit
// and reset-slot position of the frame and issues pixel reads.
// ----------------------------------------------------------------------------
module lfe_slot_ctrl
  import lfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic [9:0]        led_index,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [WORD_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  output logic              tick,
  output slot_info_t        info,
  output ctrl_status_t      status
);

  logic             sending;
  logic [LED_W-1:0] led_cnt;
  logic [BIT_W-1:0] bit_cnt;
  logic [RST_W-1:0] rst_cnt;
  logic             in_data;
  logic             last_bit;

  assign in_data  = ({1'b0, led_cnt} < (LED_W + 1)'(NUM_LEDS));
  assign last_bit = (bit_cnt == BIT_W'(BITS_PER_LED - 1));

  assign mem_we    = accept && (action == ACT_WRITE)
                     && ({1'b0, led_index} < 11'(NUM_LEDS));
  assign mem_waddr = led_index[ADDR_W-1:0];
  assign mem_wdata = {green, red, blue};

  assign tick = accept && (action == ACT_TICK);

  always_comb begin
    info.active    = sending;
    info.in_data   = in_data;
    info.bit_idx   = bit_cnt;
    info.load      = sending && in_data && (bit_cnt == '0);
    info.frame_end = sending && !in_data && (rst_cnt == RST_W'(RESET_SLOTS - 1));
  end

  assign mem_re    = tick && info.load;
  assign mem_raddr = led_cnt[ADDR_W-1:0];

  assign status.sending = sending;
  assign status.in_data = in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      sending <= 1'b0;
      led_cnt <= '0;
      bit_cnt <= '0;
      rst_cnt <= '0;
    end else if (accept && (action == ACT_START) && !sending) begin
      sending <= 1'b1;
      led_cnt <= '0;
      bit_cnt <= '0;
      rst_cnt <= '0;
    end else if (tick && sending) begin
      if (in_data) begin
        if (last_bit) begin
          bit_cnt <= '0;
          led_cnt <= led_cnt + 1'b1;
        end else begin
          bit_cnt <= bit_cnt + 1'b1;
        end
      end else if (info.frame_end) begin
        sending <= 1'b0;
        led_cnt <= '0;
        rst_cnt <= '0;
      end else begin
        rst_cnt <= rst_cnt + 1'b1;
      end
    end
  end

endmodule

FILE: sv/lfe_encode.sv
// ----------------------------------------------------------------------------
// lfe_encode
// Encoder stage: scales the pixel read from the store, keeps the current
// word and turns one bit per slot into a duty value in the output register.
// ----------------------------------------------------------------------------
module lfe_encode
  import lfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              tick,
  input  slot_info_t        info,
  input  logic [WORD_W-1:0] pixel,
  input  logic [5:0]        brightness,
  input  logic [7:0]        duty_one,
  input  logic [7:0]        duty_zero,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_duty,
  output logic              out_active,
  output logic              out_end
);

  logic              stage_valid;
  slot_info_t        stage_info;
  logic [WORD_W-1:0] current_word;
  logic              out_free;
  logic              advance;
  logic [GAIN_W-1:0] gain;
  logic [WORD_W-1:0] scaled;
  logic [WORD_W-1:0] word_now;
  logic [BIT_W-1:0]  bit_pos;
  logic [7:0]        duty_next;

  function automatic logic [7:0] scale(input logic [7:0] v, input logic [GAIN_W-1:0] g);
    logic [GAIN_W+7:0] p;
    p = {{GAIN_W{1'b0}}, v} * {8'd0, g};
    return p[23:16];
  endfunction

  assign out_free = !out_valid || out_ready;
  assign advance  = stage_valid && out_free;
  assign ready    = !stage_valid || out_free;

  assign gain   = tan_q16(brightness);
  assign scaled = {scale(pixel[23:16], gain), scale(pixel[15:8], gain),
                   scale(pixel[7:0], gain)};

  always_comb begin
    word_now  = stage_info.load ? scaled : current_word;
    bit_pos   = BIT_W'(WORD_W - 1) - stage_info.bit_idx;
    duty_next = 8'd0;
    if (stage_info.active && stage_info.in_data) begin
      duty_next = word_now[bit_pos] ? duty_one : duty_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      stage_info <= info;
    end
    if (advance) begin
      out_duty   <= duty_next;
      out_active <= stage_info.active;
      out_end    <= stage_info.frame_end;
      if (stage_info.load) begin
        current_word <= scaled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (tick) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sim/tb_addressable_led_frame_encoder_top.sv
// ----------------------------------------------------------------------------
// tb_addressable_led_frame_encoder_top
// Self-checking bench for the LED frame encoder. Pixel writes, frame starts,
// slot ticks and unused codes are streamed in with random gaps, and the
// output side stalls at random. A scoreboard keeps its own pixel store, frame
// position and brightness gain, predicts one duty transfer per tick, and
// checks every output transfer in order. Register settings change between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_addressable_led_frame_encoder_top
  import lfe_pkg::*;
();

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned NUM_PHASES  = 4;
  localparam int unsigned PHASE_ITEMS = 205;

  localparam int unsigned TAN_GAIN [46] = '{
    0, 1144, 2289, 3435, 4583, 5734, 6888, 8047, 9210, 10380,
    11556, 12739, 13930, 15130, 16340, 17560, 18792, 20036, 21294,
    22566, 23853, 25157, 26478, 27818, 29179, 30560, 31964, 33392,
    34846, 36327, 37837, 39378, 40951, 42560, 44205, 45889, 47615,
    49385, 51202, 53070, 54991, 56970, 59009, 61113, 63287, 65536
  };

  typedef struct packed {
    logic [7:0] duty;
    logic       active;
    logic       last;
  } slot_t;

  class duty_scoreboard;
    logic [23:0] pixels [NUM_LEDS];
    int unsigned slot;
    bit          sending;
    logic [23:0] word;
    logic [5:0]  bright;
    logic [7:0]  duty_hi;
    logic [7:0]  duty_lo;
    slot_t       expected [$];
    int unsigned errors;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      slot    = 0;
      sending = 0;
      word    = '0;
      bright  = BRIGHTNESS_RESET;
      duty_hi = DUTY_ONE_RESET;
      duty_lo = DUTY_ZERO_RESET;
      errors  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_BRIGHTNESS: bright = (val[5:0] > MAX_ANGLE) ? 6'(MAX_ANGLE) : val[5:0];
        REG_DUTY_ONE:   duty_hi = val;
        REG_DUTY_ZERO:  duty_lo = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] scale(logic [7:0] v);
      return 8'((32'(v) * TAN_GAIN[bright]) >> 16);
    endfunction

    function void predict_slot();
      slot_t       s;
      int unsigned bitn;
      logic [23:0] px;
      s = '0;
      if (sending) begin
        s.active = 1'b1;
        if (slot < NUM_LEDS * BITS_PER_LED) begin
          bitn = slot % BITS_PER_LED;
          if (bitn == 0) begin
            px   = pixels[slot / BITS_PER_LED];
            word = {scale(px[23:16]), scale(px[15:8]), scale(px[7:0])};
          end
          s.duty = word[23 - bitn] ? duty_hi : duty_lo;
        end else if (slot + 1 >= NUM_LEDS * BITS_PER_LED + RESET_SLOTS) begin
          s.last = 1'b1;
        end
        if (s.last) begin
          sending = 0;
          slot    = 0;
        end else begin
          slot = slot + 1;
        end
      end
      expected.push_back(s);
    endfunction

    function void note_transfer(logic [1:0] act, logic [39:0] data);
      case (act)
        ACT_WRITE: begin
          if (data[9:0] < NUM_LEDS)
            pixels[data[9:0]] = {data[25:18], data[17:10], data[33:26]};
        end
        ACT_START: begin
          if (!sending) begin
            sending = 1;
            slot    = 0;
          end
        end
        ACT_TICK: predict_slot();
        default: ;
      endcase
    endfunction

    function void check_slot(logic [7:0] duty, logic active, logic last);
      slot_t e;
      if (expected.size() == 0) begin
        $display("%0t: output transfer with nothing expected: duty %0d active %0d end %0d",
                 $time, duty, active, last);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (duty !== e.duty) begin
        $display("%0t: duty expected %0d, actual %0d", $time, e.duty, duty);
        errors++;
      end
      if (active !== e.active) begin
        $display("%0t: frame_active expected %0d, actual %0d", $time, e.active, active);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: frame_end expected %0d, actual %0d", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  duty_scoreboard sb;
  bit             quiet;
  int unsigned    received;
  int unsigned    cycles;

  addressable_led_frame_encoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial received = 0;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_slot(m_tdata, m_tuser[0], m_tlast);
      received = received + 1;
    end
  end

  // Output side: short random stalls, plus one long hold-off that backs up
  // the block until its input side stalls.
  initial begin : receiver
    int unsigned hold;
    bit          long_done;
    hold      = 0;
    long_done = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready = 1'b0;
        hold     = hold - 1;
      end else if (!long_done && received >= 300) begin
        long_done = 1;
        hold      = 79;
        m_tready  = 1'b0;
      end else if (!quiet && $urandom_range(5) == 0) begin
        hold     = $urandom_range(3);
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  function automatic logic [39:0] pixel_item(int idx, int r, int g, int b);
    return {6'd0, 8'(b), 8'(g), 8'(r), 10'(idx)};
  endfunction

  function automatic logic [39:0] random_payload();
    return {6'd0, 2'($urandom_range(3)), 32'($urandom)};
  endfunction

  // Entered and left at a falling edge.
  task automatic send_item(logic [1:0] act, logic [39:0] data);
    int unsigned gap;
    if (!quiet && $urandom_range(3) == 0) begin
      gap      = $urandom_range(1, 4);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = data;
    do @(posedge clk); while (!s_tready);
    sb.note_transfer(act, data);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(99);
    if (pick < 82) begin
      send_item(ACT_TICK, random_payload());
    end else if (pick < 93) begin
      idx = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(NUM_LEDS - 1);
      send_item(ACT_WRITE, pixel_item(idx, $urandom_range(255), $urandom_range(255),
                                      $urandom_range(255)));
    end else if (pick < 98) begin
      send_item(ACT_START, random_payload());
    end else begin
      send_item(ACT_UNUSED, random_payload());
    end
  endtask

  initial begin : stimulus
    logic [7:0] bright_cfg [NUM_PHASES];
    logic [7:0] one_cfg    [NUM_PHASES];
    logic [7:0] zero_cfg   [NUM_PHASES];
    sb        = new();
    quiet     = 0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = ACT_WRITE;
    cfg_we    = 1'b0;
    cfg_index = REG_BRIGHTNESS;
    cfg_data  = '0;

    bright_cfg = '{8'd0, 8'd63, 8'd44, 8'($urandom_range(63))};
    one_cfg    = '{8'd255, 8'd0, 8'($urandom_range(255)), 8'($urandom_range(255))};
    zero_cfg   = '{8'd0, 8'd255, 8'($urandom_range(255)), 8'($urandom_range(255))};

    repeat (12) @(negedge clk);
    rst = 1'b0;

    send_item(ACT_TICK, random_payload());
    send_item(ACT_UNUSED, random_payload());
    send_item(ACT_WRITE, pixel_item(0, 255, 0, 255));
    send_item(ACT_WRITE, pixel_item(NUM_LEDS - 1, 0, 255, 0));
    send_item(ACT_WRITE, pixel_item(1, 255, 255, 255));
    send_item(ACT_WRITE, pixel_item(NUM_LEDS, 255, 255, 255));
    send_item(ACT_WRITE, pixel_item(1023, 255, 255, 255));
    send_item(ACT_WRITE, pixel_item(512, 8'h55, 8'haa, 8'h55));
    send_item(ACT_START, random_payload());
    repeat (3) send_item(ACT_TICK, random_payload());
    send_item(ACT_START, random_payload());
    send_item(ACT_WRITE, pixel_item(0, 0, 0, 0));
    send_item(ACT_UNUSED, random_payload());
    repeat (3) send_item(ACT_TICK, random_payload());

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(REG_BRIGHTNESS, bright_cfg[p]);
      write_reg(REG_DUTY_ONE, one_cfg[p]);
      write_reg(REG_DUTY_ZERO, zero_cfg[p]);
      quiet = (p == NUM_PHASES - 1);
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
